>>> src/bho_pkg.sv
// Shared types and constants of the bucketed histogram observer.
`timescale 1ns / 1ps
package bho_pkg;

	// Maximum number of finite bucket bounds; the overflow bucket sits after them.
	localparam int MAX_BOUNDS = 6;
	localparam int NUM_CELLS  = MAX_BOUNDS + 1;

	// Field widths.
	localparam int IDX_W      = 3;
	localparam int VAL_W      = 32;
	localparam int CNT_W      = 64;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_NUM_BOUNDS  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BOUND_FIRST = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BOUND_LAST  = 3'd6;

	// One item as it travels down the row of bucket cells.
	typedef struct packed {
		logic [VAL_W-1:0] value;
		logic             matched;
		logic [IDX_W-1:0] index;
		logic [CNT_W-1:0] bucket_total;
		logic [CNT_W-1:0] sample_total;
		logic [CNT_W-1:0] value_sum;
	} item_t;

endpackage

>>> src/bucketed_histogram_observer.sv
// Top level of the bucketed histogram observer: configuration and the row of cells.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  input   | in_valid, in_ready, value_milli           | in
//  result  | out_valid, out_ready, bin_index,          | out
//          | bucket_total, sample_total, value_sum     |
//  config  | cfg_valid, cfg_ready, cfg_index, cfg_data | in
//
// One item is taken per cycle unless the output stalls the row; each result passes through
// one register per bucket cell along the row of seven cells.
// Each cell stalls on its own, so the row fills up its gaps while the output waits.
// Reset clears all counts, the totals and the configuration at once.
// Configuration writes are always taken.
`timescale 1ns / 1ps
module bucketed_histogram_observer (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [bho_pkg::VAL_W-1:0]      value_milli,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [bho_pkg::IDX_W-1:0]      bin_index,
	output logic [bho_pkg::CNT_W-1:0]      bucket_total,
	output logic [bho_pkg::CNT_W-1:0]      sample_total,
	output logic [bho_pkg::CNT_W-1:0]      value_sum,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [bho_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bho_pkg::CFG_DATA_W-1:0] cfg_data
);
	import bho_pkg::*;

	logic [IDX_W-1:0] num_bounds_q;
	logic [VAL_W-1:0] bound_q [MAX_BOUNDS];
	logic [IDX_W-1:0] num_active;
	logic [CNT_W-1:0] sample_next;
	logic [CNT_W-1:0] sum_next;

	logic             cell_valid [NUM_CELLS+1];
	logic             cell_ready [NUM_CELLS+1];
	item_t            cell_item  [NUM_CELLS+1];
	logic [VAL_W-1:0] cell_bound [NUM_CELLS];

	// Configuration registers; unknown indexes are dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_bounds_q <= '0;
			for (int k = 0; k < MAX_BOUNDS; k++) begin
				bound_q[k] <= '0;
			end
		end else if (cfg_valid) begin
			case (cfg_index) inside
				REG_NUM_BOUNDS: begin
					num_bounds_q <= cfg_data[IDX_W-1:0];
				end
				[REG_BOUND_FIRST:REG_BOUND_LAST]: begin
					bound_q[cfg_index - REG_BOUND_FIRST] <= cfg_data[VAL_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// A bound count above the maximum acts as the maximum.
	assign num_active = (num_bounds_q > IDX_W'(MAX_BOUNDS)) ? IDX_W'(MAX_BOUNDS)
		: num_bounds_q;

	// Totals are settled as the item enters and ride along with it.
	bho_totals u_totals (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (in_valid && in_ready),
		.value       (value_milli),
		.sample_next (sample_next),
		.sum_next    (sum_next)
	);

	// Entry of the row.
	assign cell_valid[0]             = in_valid;
	assign in_ready                  = cell_ready[0];
	assign cell_item[0].value        = value_milli;
	assign cell_item[0].matched      = 1'b0;
	assign cell_item[0].index        = '0;
	assign cell_item[0].bucket_total = '0;
	assign cell_item[0].sample_total = sample_next;
	assign cell_item[0].value_sum    = sum_next;

	// The row of bucket cells; the last one has no finite bound.
	for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
		if (k < MAX_BOUNDS) begin : g_bound
			assign cell_bound[k] = bound_q[k];
		end else begin : g_overflow
			assign cell_bound[k] = '0;
		end

		bho_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cell_index (IDX_W'(k)),
			.num_active (num_active),
			.bound      (cell_bound[k]),
			.in_valid   (cell_valid[k]),
			.in_ready   (cell_ready[k]),
			.in_item    (cell_item[k]),
			.out_valid  (cell_valid[k+1]),
			.out_ready  (cell_ready[k+1]),
			.out_item   (cell_item[k+1])
		);
	end

	// Exit of the row drives the result channel.
	assign out_valid                = cell_valid[NUM_CELLS];
	assign cell_ready[NUM_CELLS]    = out_ready;
	assign bin_index                = cell_item[NUM_CELLS].index;
	assign bucket_total             = cell_item[NUM_CELLS].bucket_total;
	assign sample_total             = cell_item[NUM_CELLS].sample_total;
	assign value_sum                = cell_item[NUM_CELLS].value_sum;

endmodule

>>> src/bho_totals.sv
// Total observation count and running sum, updated as each item enters.
`timescale 1ns / 1ps
module bho_totals (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       accept,
	input  logic [bho_pkg::VAL_W-1:0]  value,
	output logic [bho_pkg::CNT_W-1:0]  sample_next,
	output logic [bho_pkg::CNT_W-1:0]  sum_next
);
	import bho_pkg::*;

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] sum_q;

	// Values after this item; both wrap at the counter width.
	assign sample_next = count_q + CNT_W'(1);
	assign sum_next    = sum_q + CNT_W'(value);

	// The totals advance only when an item is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
		end else if (accept) begin
			count_q <= sample_next;
			sum_q   <= sum_next;
		end
	end

endmodule

>>> src/bho_cell.sv
// One bucket cell: compares against its bound, keeps its count, passes the item on.
`timescale 1ns / 1ps
module bho_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [bho_pkg::IDX_W-1:0] cell_index,
	input  logic [bho_pkg::IDX_W-1:0] num_active,
	input  logic [bho_pkg::VAL_W-1:0] bound,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  bho_pkg::item_t            in_item,
	output logic                      out_valid,
	input  logic                      out_ready,
	output bho_pkg::item_t            out_item
);
	import bho_pkg::*;

	logic             valid_q;
	logic [CNT_W-1:0] count_q;
	item_t            data_q;
	item_t            next_item;
	logic             accept;
	logic             hit;

	// The stage takes an item when it is empty or its item moves on.
	assign in_ready  = !valid_q || out_ready;
	assign accept    = in_valid && in_ready;
	assign out_valid = valid_q;
	assign out_item  = data_q;

	// This cell claims the item if no earlier cell did and either it is the
	// overflow bucket for the current bound count or its active bound covers it.
	assign hit = !in_item.matched &&
		((cell_index == num_active) ||
		 ((cell_index < num_active) && (in_item.value <= bound)));

	// A claimed item picks up this bucket's index and new count.
	always_comb begin
		next_item = in_item;
		if (hit) begin
			next_item.matched      = 1'b1;
			next_item.index        = cell_index;
			next_item.bucket_total = count_q + CNT_W'(1);
		end
	end

	// Stage occupancy and the bucket count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			count_q <= '0;
		end else begin
			if (in_ready) begin
				valid_q <= in_valid;
			end
			if (accept && hit) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	// Item payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			data_q <= next_item;
		end
	end

	// The overflow cell always claims an item that is still unclaimed.
	a_overflow_claims: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !in_item.matched && (cell_index == num_active)) |=> data_q.matched)
		else $error("unclaimed item passed its overflow cell");

	// An item claimed upstream leaves this count alone.
	a_claimed_passes: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_item.matched) |=> $stable(count_q))
		else $error("count changed for an item claimed elsewhere");

	// A claim reports this cell and the count it now holds.
	a_claim_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && hit) |=> (data_q.index == cell_index) && (data_q.bucket_total == count_q))
		else $error("claimed item carries wrong bucket index or count");

endmodule

>>> bench/bucketed_histogram_observer_tb.sv
// Self-checking bench for the bucketed histogram observer: directed table, then random phases.
`timescale 1ns / 1ps
module bucketed_histogram_observer_tb;
	import bho_pkg::*;

	// Result as it leaves the block.
	typedef struct packed {
		logic [IDX_W-1:0] index;
		logic [CNT_W-1:0] bucket_total;
		logic [CNT_W-1:0] sample_total;
		logic [CNT_W-1:0] value_sum;
	} bin_result_t;

	typedef enum logic {ROW_VALUE, ROW_CFG} row_kind_t;

	// One row of the directed table: an item or a register write.
	typedef struct packed {
		row_kind_t              kind;
		logic [CFG_IDX_W-1:0]   reg_index;
		logic [CFG_DATA_W-1:0]  data;
		logic                   has_want;
		bin_result_t            want;
	} stim_row_t;

	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = REG_BOUND_LAST + 3'd1;
	localparam bin_result_t NO_WANT = '0;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int HOLD_CYCLES    = 400;
	localparam int DRAIN_CYCLES   = 32;
	localparam int BLOCK_ITEMS    = 52;
	localparam int MAX_REPORTS    = 10;

	// Only the first rows after reset carry a typed-in result; the rest use the predictor.
	localparam stim_row_t DIRECTED [31] = '{
		'{ROW_VALUE, REG_NUM_BOUNDS, 32'h0000_0000, 1'b1,
			'{3'd0, 64'd1, 64'd1, 64'h0000_0000_0000_0000}},
		'{ROW_VALUE, REG_NUM_BOUNDS, 32'hFFFF_FFFF, 1'b1,
			'{3'd0, 64'd2, 64'd2, 64'h0000_0000_FFFF_FFFF}},
		'{ROW_CFG, REG_BOUND_FIRST,         32'd100,       1'b0, NO_WANT},
		'{ROW_CFG, REG_BOUND_FIRST + 3'd1,  32'd1000,      1'b0, NO_WANT},
		'{ROW_CFG, REG_BOUND_FIRST + 3'd2,  32'd0,         1'b0, NO_WANT},
		'{ROW_CFG, REG_BOUND_FIRST + 3'd3,  32'd5000,      1'b0, NO_WANT},
		'{ROW_CFG, REG_BOUND_FIRST + 3'd4,  32'd8000,      1'b0, NO_WANT},
		'{ROW_CFG, REG_BOUND_LAST,          32'hFFFF_FFFE, 1'b0, NO_WANT},
		'{ROW_CFG, REG_NUM_BOUNDS,          32'd4,         1'b0, NO_WANT},
		'{ROW_VALUE, REG_NUM_BOUNDS, 32'd100,       1'b0, NO_WANT},
		'{ROW_VALUE, REG_NUM_BOUNDS, 32'd101,       1'b0, NO_WANT},
		'{ROW_VALUE, REG_NUM_BOUNDS, 32'd1000,      1'b0, NO_WANT},
		'{ROW_VALUE, REG_NUM_BOUNDS, 32'd1001,      1'b0, NO_WANT},
		'{ROW_VALUE, REG_NUM_BOUNDS, 32'd0,         1'b0, NO_WANT},
		'{ROW_VALUE, REG_NUM_BOUNDS, 32'hFFFF_FFFF, 1'b0, NO_WANT},
		'{ROW_CFG, REG_NUM_BOUNDS,          32'hFFFF_FFFF, 1'b0, NO_WANT},
		'{ROW_VALUE, REG_NUM_BOUNDS, 32'd6000,      1'b0, NO_WANT},
		'{ROW_VALUE, REG_NUM_BOUNDS, 32'hFFFF_FFFE, 1'b0, NO_WANT},
		'{ROW_VALUE, REG_NUM_BOUNDS, 32'hFFFF_FFFF, 1'b0, NO_WANT},
		'{ROW_VALUE, REG_NUM_BOUNDS, 32'd5000,      1'b0, NO_WANT},
		'{ROW_CFG, REG_UNMAPPED,            32'h0000_0001, 1'b0, NO_WANT},
		'{ROW_VALUE, REG_NUM_BOUNDS, 32'd8000,      1'b0, NO_WANT},
		'{ROW_CFG, REG_NUM_BOUNDS,          32'd0,         1'b0, NO_WANT},
		'{ROW_VALUE, REG_NUM_BOUNDS, 32'd12345,     1'b0, NO_WANT},
		'{ROW_VALUE, REG_NUM_BOUNDS, 32'hFFFF_FFFF, 1'b0, NO_WANT},
		'{ROW_CFG, REG_NUM_BOUNDS,          32'hFFFF_FFF9, 1'b0, NO_WANT},
		'{ROW_VALUE, REG_NUM_BOUNDS, 32'd100,       1'b0, NO_WANT},
		'{ROW_VALUE, REG_NUM_BOUNDS, 32'd101,       1'b0, NO_WANT},
		'{ROW_CFG, REG_BOUND_FIRST,         32'hFFFF_FFFF, 1'b0, NO_WANT},
		'{ROW_VALUE, REG_NUM_BOUNDS, 32'hFFFF_FFFF, 1'b0, NO_WANT},
		'{ROW_CFG, REG_NUM_BOUNDS,          32'd6,         1'b0, NO_WANT}
	};

	logic                  clk         = 1'b0;
	logic                  arst_n      = 1'b0;
	logic                  in_valid    = 1'b0;
	logic                  in_ready;
	logic [VAL_W-1:0]      value_milli = '0;
	logic                  out_valid;
	logic                  out_ready   = 1'b0;
	logic [IDX_W-1:0]      bin_index;
	logic [CNT_W-1:0]      bucket_total;
	logic [CNT_W-1:0]      sample_total;
	logic [CNT_W-1:0]      value_sum;
	logic                  cfg_valid   = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index   = '0;
	logic [CFG_DATA_W-1:0] cfg_data    = '0;

	// Predictor state: configuration copy and histogram contents.
	logic [2:0]       bounds_active_reg;
	logic [VAL_W-1:0] bound_reg [MAX_BOUNDS];
	logic [CNT_W-1:0] bin_counts [NUM_CELLS];
	logic [CNT_W-1:0] observed_total;
	logic [CNT_W-1:0] observed_sum;
	int               bin_hits [NUM_CELLS];

	bin_result_t expected_bins [$];

	int send_idle_pct  = 0;
	int stall_pct      = 0;
	int hold_requests  = 0;
	int holds_served   = 0;
	int hold_left      = 0;
	int mismatch_count = 0;
	int items_sent     = 0;
	int results_seen   = 0;
	int reg_writes     = 0;
	int quiet_cycles   = 0;

	bucketed_histogram_observer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.value_milli  (value_milli),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.bin_index    (bin_index),
		.bucket_total (bucket_total),
		.sample_total (sample_total),
		.value_sum    (value_sum),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Bins one value into the predictor and returns the result the block should give.
	function automatic bin_result_t bin_value(input logic [VAL_W-1:0] v);
		int          n;
		int          sel;
		int          i;
		bin_result_t res;
		n = (bounds_active_reg > MAX_BOUNDS) ? MAX_BOUNDS : int'(bounds_active_reg);
		sel = n;
		for (i = n - 1; i >= 0; i--) begin
			if (v <= bound_reg[i]) sel = i;
		end
		bin_counts[sel] = bin_counts[sel] + 64'd1;
		observed_total  = observed_total + 64'd1;
		observed_sum    = observed_sum + {32'd0, v};
		bin_hits[sel]++;
		res.index        = IDX_W'(sel);
		res.bucket_total = bin_counts[sel];
		res.sample_total = observed_total;
		res.value_sum    = observed_sum;
		return res;
	endfunction

	// Offers one item, honouring the sender idle rate, and records its expected result.
	task automatic send_value(input logic [VAL_W-1:0] v, input logic has_want,
			input bin_result_t want);
		bin_result_t res;
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		value_milli <= v;
		@(posedge clk);
		while (in_ready !== 1'b1) @(posedge clk);
		res = bin_value(v);
		if (has_want) res = want;
		expected_bins.push_back(res);
		items_sent++;
	endtask

	// Writes one register once every outstanding result has arrived.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		in_valid <= 1'b0;
		while (expected_bins.size() != 0) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (cfg_ready !== 1'b1) @(posedge clk);
		if (idx == REG_NUM_BOUNDS) begin
			bounds_active_reg = data[2:0];
		end else if (idx >= REG_BOUND_FIRST && idx <= REG_BOUND_LAST) begin
			bound_reg[idx - REG_BOUND_FIRST] = data;
		end
		reg_writes++;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// New random settings; the first blocks force the bound count extremes.
	task automatic reconfigure(input int blk);
		int               k;
		logic [VAL_W-1:0] b;
		logic [31:0]      nb_word;
		for (k = 0; k < MAX_BOUNDS; k++) begin
			if (blk < 2 || $urandom_range(3) != 0) begin
				case ($urandom_range(3))
					0: begin
						b = $urandom;
					end
					1: begin
						b = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0000_0000;
					end
					default: begin
						b = (k + 1) * $urandom_range(600_000_000);
					end
				endcase
				write_reg(REG_BOUND_FIRST + 3'(k), b);
			end
		end
		nb_word = $urandom;
		case (blk)
			0: nb_word[2:0] = 3'd0;
			1: nb_word[2:0] = 3'd7;
			2: nb_word[2:0] = 3'd6;
			default: nb_word[2:0] = 3'($urandom_range(7));
		endcase
		write_reg(REG_NUM_BOUNDS, nb_word);
		if ($urandom_range(3) == 0) write_reg(REG_UNMAPPED, $urandom);
	endtask

	// Random value, biased towards the extremes and the edges of the bounds.
	function automatic logic [VAL_W-1:0] pick_value();
		logic [VAL_W-1:0] b;
		case ($urandom_range(9))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2, 3, 4, 5: begin
				b = bound_reg[3'($urandom_range(MAX_BOUNDS - 1))];
				return b + 32'($urandom_range(2)) - 32'd1;
			end
			6: return 32'($urandom_range(10_000));
			default: return $urandom;
		endcase
	endfunction

	// Result side: checks each accepted result, then sets the next ready.
	always @(posedge clk) begin
		bin_result_t got;
		bin_result_t want;
		if (out_valid === 1'b1 && out_ready === 1'b1) begin
			got = '{bin_index, bucket_total, sample_total, value_sum};
			results_seen++;
			if (expected_bins.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("unexpected result: bucket %0d count %0d total %0d sum %0d",
						got.index, got.bucket_total, got.sample_total, got.value_sum);
			end else begin
				want = expected_bins.pop_front();
				if (got !== want) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS) begin
						$display("result %0d mismatch: expected bucket %0d count %0d total %0d sum %0d",
							results_seen, want.index, want.bucket_total, want.sample_total,
							want.value_sum);
						$display("                  got      bucket %0d count %0d total %0d sum %0d",
							got.index, got.bucket_total, got.sample_total, got.value_sum);
					end
				end
			end
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (hold_requests != holds_served) begin
			holds_served++;
			hold_left = HOLD_CYCLES - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Watchdog: ends the run if no channel moves an item for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles", quiet_cycles);
			$display("DONE: errors detected");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Main sequence: reset, directed table, four idle and stall mixes of random blocks, drain.
	initial begin
		int row;
		int phase;
		int blk;
		int n;
		int leftover;
		bounds_active_reg = '0;
		observed_total    = '0;
		observed_sum      = '0;
		for (n = 0; n < MAX_BOUNDS; n++) bound_reg[n] = '0;
		for (n = 0; n < NUM_CELLS; n++) begin
			bin_counts[n] = '0;
			bin_hits[n]   = 0;
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (row = 0; row < $size(DIRECTED); row++) begin
			if (DIRECTED[row].kind == ROW_CFG)
				write_reg(DIRECTED[row].reg_index, DIRECTED[row].data);
			else
				send_value(DIRECTED[row].data, DIRECTED[row].has_want, DIRECTED[row].want);
		end

		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 86; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 86; end
				default: begin send_idle_pct = 16; stall_pct = 16; end
			endcase
			for (blk = 0; blk < 4; blk++) begin
				reconfigure(phase * 4 + blk);
				// Long output hold-off while items keep coming, so the row fills and stalls.
				if (phase * 4 + blk == 1 || phase * 4 + blk == 13) hold_requests++;
				for (n = 0; n < BLOCK_ITEMS; n++) send_value(pick_value(), 1'b0, NO_WANT);
			end
		end

		in_valid <= 1'b0;
		while (expected_bins.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		leftover = expected_bins.size();
		$display("Run covered %0d items and %0d register writes across four idle/stall mixes,",
			items_sent, reg_writes);
		$display("two long output hold-offs; %0d results checked, bucket hits %0d %0d %0d %0d %0d %0d %0d.",
			results_seen, bin_hits[0], bin_hits[1], bin_hits[2], bin_hits[3],
			bin_hits[4], bin_hits[5], bin_hits[6]);
		if (mismatch_count == 0 && leftover == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("%0d mismatches, %0d results missing", mismatch_count, leftover);
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
